// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the keypad command block.
// Each macro checks on the rising edge of clk, with checks off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds in the same cycle
`define LBPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequence holds in the cycle after the antecedent
`define LBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lbpc_pkg.sv -----
// Shared types, constants and decode helpers for the keypad command block.
// No dependencies; used by every module of the block.
package lbpc_pkg;

	// Default widths of the sample and the millisecond time
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int TIME_BITS_DEF = 32;

	// Command queue between the front and back parts
	localparam int CMD_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LONG_PRESS = 3'd0,
		REG_TIMEOUT    = 3'd1,
		REG_BUTTON1    = 3'd2,
		REG_BUTTON2    = 3'd3,
		REG_BUTTON3    = 3'd4,
		REG_PAIR12     = 3'd5,
		REG_PAIR23     = 3'd6,
		REG_PAIR13     = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [15:0] TIMEOUT_RST = 16'd200;
	typedef logic [25:0] range_t;
	typedef range_t [5:0] range_arr_t;
	localparam range_t BUTTON1_RST = 26'd13107350;
	localparam range_t BUTTON2_RST = 26'd55706400;
	localparam range_t BUTTON3_RST = 26'd60949400;
	localparam range_t PAIR12_RST = 26'd32768400;
	localparam range_t PAIR23_RST = 26'd60294030;
	localparam range_t PAIR13_RST = 26'd41288300;

	// Decoded key
	typedef enum logic [2:0] {
		BTN_NONE = 3'd0,
		BTN_1    = 3'd1,
		BTN_2    = 3'd2,
		BTN_3    = 3'd3,
		BTN_12   = 3'd4,
		BTN_23   = 3'd5,
		BTN_13   = 3'd6
	} btn_t;

	// Command bytes
	localparam logic [7:0] BYTE_PREFIX = 8'd160;
	localparam logic [7:0] BYTE_CMD = 8'd130;
	localparam logic [7:0] BYTE_RELEASE = 8'd0;
	localparam logic [7:0] CODE_END = 8'd1;
	localparam logic [7:0] CODE_CALL = 8'd2;
	localparam logic [7:0] CODE_RESET = 8'd3;
	localparam logic [7:0] CODE_MENU = 8'd4;
	localparam logic [7:0] CODE_UP = 8'd8;
	localparam logic [7:0] CODE_DOWN = 8'd248;

	// Waits before the second prefix byte
	localparam logic [10:0] WAIT_BASE = 11'd150;
	localparam logic [10:0] WAIT_REDIAL = 11'd1000;
	localparam logic [10:0] WAIT_RESET = 11'd2000;

	// Byte positions within a sequence
	localparam logic [2:0] POS_PREFIX1 = 3'd0;
	localparam logic [2:0] POS_CMD1 = 3'd1;
	localparam logic [2:0] POS_CODE = 3'd2;
	localparam logic [2:0] POS_PREFIX2 = 3'd3;
	localparam logic [2:0] POS_CMD2 = 3'd4;
	localparam logic [2:0] POS_RELEASE = 3'd5;

	// One queued command sequence
	typedef struct packed {
		logic        full_seq;  // six bytes; else three
		logic [7:0]  code;
		logic [10:0] wait_ms;   // wait before the second prefix byte
		logic        led;
	} cmd_t;

	// Pick the first range that holds the sample strictly inside it
	function automatic btn_t decode_btn(logic [15:0] v, range_arr_t r);
		btn_t b;
		b = BTN_NONE;
		for (int i = 5; i >= 0; i--) begin
			if (v > 16'(r[i][9:0]) && v < 16'(r[i][25:16])) begin
				b = btn_t'(3'(i + 1));
			end
		end
		return b;
	endfunction

	// Byte at a given position of a sequence
	function automatic logic [7:0] seq_byte(cmd_t c, logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			POS_PREFIX1, POS_PREFIX2: b = BYTE_PREFIX;
			POS_CMD1, POS_CMD2:       b = BYTE_CMD;
			POS_CODE:                 b = c.code;
			default:                  b = BYTE_RELEASE;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/lbpc_front.sv -----
// Front part: configuration registers, press timing and key decoding.
// Turns each accepted sample into at most one queued command sequence; uses lbpc_pkg.
`include "assert_macros.svh"

module lbpc_front #(
	parameter int SAMPLE_BITS = lbpc_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS = lbpc_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr,
	input  logic [2:0]             cfg_index,
	input  logic [25:0]            cfg_data,
	input  logic                   in_take,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [TIME_BITS-1:0]   now_ms,
	output logic                   cmd_wr,
	output lbpc_pkg::cmd_t         cmd
);

	logic [15:0]            long_q;
	logic [15:0]            timeout_q;
	lbpc_pkg::range_arr_t   range_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   held_q;
	logic                   long_done_q;
	logic                   menu_q;
	logic                   armed_q;

	logic                   cur_nz;
	logic                   prev_nz;
	logic [TIME_BITS-1:0]   diff;
	logic [TIME_BITS-1:0]   long_ext;
	logic                   latch;
	logic [TIME_BITS-1:0]   held_n;
	logic                   short_fire;
	logic                   long_fire;
	lbpc_pkg::btn_t         btn_prev;
	lbpc_pkg::btn_t         btn_cur;
	logic                   has_cmd;
	logic                   menu_n;
	logic                   armed_n;

	// Time the press and decode the keys
	assign cur_nz = (sample != '0);
	assign prev_nz = (prev_q != '0);
	assign diff = now_ms - start_q;
	assign long_ext = TIME_BITS'(long_q);
	assign latch = cur_nz && !prev_nz && (diff > TIME_BITS'(timeout_q));
	assign held_n = (cur_nz && !latch) ? diff : '0;
	assign short_fire = prev_nz && !cur_nz && (held_q < long_ext);
	assign long_fire = (held_n > long_ext) && !long_done_q;
	assign btn_prev = lbpc_pkg::decode_btn(16'(prev_q), range_q);
	assign btn_cur = lbpc_pkg::decode_btn(16'(sample), range_q);

	// Map the press and context to a command sequence
	always_comb begin
		has_cmd = 1'b0;
		menu_n = menu_q;
		armed_n = armed_q;
		cmd = '{full_seq: 1'b1, code: lbpc_pkg::CODE_CALL,
			wait_ms: lbpc_pkg::WAIT_BASE, led: 1'b0};
		if (short_fire) begin
			case (btn_prev)
				lbpc_pkg::BTN_1: begin
					has_cmd = 1'b1;
					if (menu_q) begin
						cmd.code = lbpc_pkg::CODE_MENU;
						cmd.led = 1'b1;
					end
				end
				lbpc_pkg::BTN_2: begin
					has_cmd = menu_q;
					cmd.full_seq = 1'b0;
					cmd.code = lbpc_pkg::CODE_DOWN;
				end
				lbpc_pkg::BTN_3: begin
					has_cmd = 1'b1;
					if (menu_q) begin
						cmd.full_seq = 1'b0;
						cmd.code = lbpc_pkg::CODE_UP;
					end else begin
						cmd.code = lbpc_pkg::CODE_END;
						menu_n = 1'b0;
					end
				end
				default: begin
					has_cmd = 1'b0;
				end
			endcase
		end else if (long_fire) begin
			case (btn_cur)
				lbpc_pkg::BTN_1: begin
					has_cmd = 1'b1;
					if (armed_q) begin
						cmd.code = lbpc_pkg::CODE_RESET;
						cmd.wait_ms = lbpc_pkg::WAIT_RESET;
						armed_n = 1'b0;
					end else begin
						cmd.wait_ms = lbpc_pkg::WAIT_REDIAL;
					end
				end
				lbpc_pkg::BTN_2: begin
					has_cmd = 1'b1;
					cmd.code = lbpc_pkg::CODE_MENU;
					cmd.led = 1'b1;
					menu_n = 1'b1;
				end
				lbpc_pkg::BTN_3: begin
					has_cmd = menu_q;
					cmd.code = lbpc_pkg::CODE_END;
					menu_n = 1'b0;
				end
				lbpc_pkg::BTN_23: begin
					armed_n = 1'b1;
				end
				default: begin
					has_cmd = 1'b0;
				end
			endcase
		end
		// Short press of button one with the menu on also opens the menu
		if (short_fire && btn_prev == lbpc_pkg::BTN_1 && menu_q) begin
			menu_n = 1'b1;
		end
	end

	assign cmd_wr = in_take && has_cmd;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= lbpc_pkg::LONG_PRESS_RST;
			timeout_q <= lbpc_pkg::TIMEOUT_RST;
			range_q[0] <= lbpc_pkg::BUTTON1_RST;
			range_q[1] <= lbpc_pkg::BUTTON2_RST;
			range_q[2] <= lbpc_pkg::BUTTON3_RST;
			range_q[3] <= lbpc_pkg::PAIR12_RST;
			range_q[4] <= lbpc_pkg::PAIR23_RST;
			range_q[5] <= lbpc_pkg::PAIR13_RST;
		end else if (cfg_wr) begin
			case (lbpc_pkg::reg_idx_t'(cfg_index))
				lbpc_pkg::REG_LONG_PRESS: long_q <= cfg_data[15:0];
				lbpc_pkg::REG_TIMEOUT:    timeout_q <= cfg_data[15:0];
				lbpc_pkg::REG_BUTTON1:    range_q[0] <= cfg_data;
				lbpc_pkg::REG_BUTTON2:    range_q[1] <= cfg_data;
				lbpc_pkg::REG_BUTTON3:    range_q[2] <= cfg_data;
				lbpc_pkg::REG_PAIR12:     range_q[3] <= cfg_data;
				lbpc_pkg::REG_PAIR23:     range_q[4] <= cfg_data;
				lbpc_pkg::REG_PAIR13:     range_q[5] <= cfg_data;
				default:                  long_q <= long_q;
			endcase
		end
	end

	// Advance press state on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			start_q <= '0;
			held_q <= '0;
			long_done_q <= 1'b0;
			menu_q <= 1'b0;
			armed_q <= 1'b0;
		end else if (in_take) begin
			prev_q <= sample;
			if (!cur_nz) begin
				start_q <= '0;
			end else if (latch) begin
				start_q <= now_ms;
			end
			held_q <= held_n;
			if (long_fire) begin
				long_done_q <= 1'b1;
			end else if (prev_nz && !cur_nz) begin
				long_done_q <= 1'b0;
			end
			menu_q <= menu_n;
			armed_q <= armed_n;
		end
	end

	// A release and a long hold never fall on the same sample
	`LBPC_ASSERT_NOW(a_one_press_kind, in_take, !(short_fire && long_fire), "short and long press together")
	// A long press is reported once per hold
	`LBPC_ASSERT_NEXT(a_long_once, in_take && long_fire, long_done_q, "long press not marked done")

endmodule

// ----- rtl/lbpc_cmd_fifo.sv -----
// Short command queue between the front and back parts.
// Holds lbpc_pkg::cmd_t entries; depth from lbpc_pkg::CMD_DEPTH.
`include "assert_macros.svh"

module lbpc_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  lbpc_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output logic           avail,
	output lbpc_pkg::cmd_t rdata
);

	localparam int DEPTH = lbpc_pkg::CMD_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lbpc_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`LBPC_ASSERT_NOW(a_no_overflow, wr, !full || rd, "write into a full command queue")
	`LBPC_ASSERT_NOW(a_no_underflow, rd, avail, "read from an empty command queue")

endmodule

// ----- rtl/lbpc_back.sv -----
// Back part: expands queued commands into bytes and holds the result register.
// Reads lbpc_pkg::cmd_t from the command queue; uses lbpc_pkg byte helpers.
`include "assert_macros.svh"

module lbpc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_avail,
	input  lbpc_pkg::cmd_t cmd,
	output logic           cmd_rd,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic [10:0]    wait_ms,
	output logic           red_led_on,
	output logic           is_last
);

	logic [2:0]  pos_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic [10:0] wait_q;
	logic        led_q;
	logic        last_q;

	logic        load;
	logic        seq_end;

	// Load the next byte when the result register is free or being taken
	assign load = cmd_avail && (!out_valid_q || pop);
	assign seq_end = cmd.full_seq ? (pos_q == lbpc_pkg::POS_RELEASE)
		: (pos_q == lbpc_pkg::POS_CODE);
	assign cmd_rd = load && seq_end;

	// Hold result payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= lbpc_pkg::seq_byte(cmd, pos_q);
			wait_q <= (pos_q == lbpc_pkg::POS_PREFIX2) ? cmd.wait_ms : '0;
			led_q <= cmd.led;
			last_q <= seq_end;
		end
	end

	// Advance byte position and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q <= seq_end ? '0 : pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign out_byte = byte_q;
	assign wait_ms = wait_q;
	assign red_led_on = led_q;
	assign is_last = last_q;

	// Mid-sequence the command must still be at the queue head
	`LBPC_ASSERT_NOW(a_head_held, pos_q != 3'd0, cmd_avail, "command left queue mid-sequence")
	// A short sequence never runs past its code byte
	`LBPC_ASSERT_NOW(a_step_len, cmd_avail && !cmd.full_seq, pos_q <= lbpc_pkg::POS_CODE, "short sequence overrun")

endmodule

// ----- rtl/ladder_button_press_commander_core.sv -----
// Keypad command block, top level: joins the front part, command queue and back part.
// Depends on lbpc_pkg, lbpc_front, lbpc_cmd_fifo and lbpc_back.
// Use:
//   Samples enter as a queue: drive sample and now_ms with push; a sample is taken
//   on a clock edge with push high and full low. Each sample gives zero, three or
//   six command bytes, read as a queue: while empty is low the oldest byte is on
//   out_byte, wait_ms, red_led_on and is_last; pop with empty low takes it.
//   is_last marks the final byte of one sample's sequence.
//   Configuration writes use cfg_valid/cfg_ready (ready always high), cfg_index
//   selecting the register and cfg_data the value; write only while idle.
// Timing:
//   A sample is decoded in the cycle it is taken; its first byte passes through the
//   command queue and the result register to the result ports. The back part sends
//   one byte per cycle while pop stays high; when every sample makes a command, the
//   byte sequencer sets the sample rate; samples enter while the queue has room.
//   Samples that make no command are taken every cycle while the queue has room.
// Stalls and reset:
//   When pop stays low the result register holds; the two-entry command queue
//   fills and then full rises. Reset clears press state, context and queues and
//   loads the default register values; no clearing pass is needed.
module ladder_button_press_commander_core #(
	parameter int SAMPLE_BITS = lbpc_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS = lbpc_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [TIME_BITS-1:0]   now_ms,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             out_byte,
	output logic [10:0]            wait_ms,
	output logic                   red_led_on,
	output logic                   is_last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [25:0]            cfg_data
);

	logic           in_take;
	logic           cmd_wr;
	lbpc_pkg::cmd_t cmd_in;
	logic           cmd_rd;
	logic           cmd_avail;
	lbpc_pkg::cmd_t cmd_head;

	assign cfg_ready = 1'b1;
	assign in_take = push && !full;

	lbpc_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_take(in_take),
		.sample(sample),
		.now_ms(now_ms),
		.cmd_wr(cmd_wr),
		.cmd(cmd_in)
	);

	lbpc_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(cmd_wr),
		.wdata(cmd_in),
		.full(full),
		.rd(cmd_rd),
		.avail(cmd_avail),
		.rdata(cmd_head)
	);

	lbpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(cmd_avail),
		.cmd(cmd_head),
		.cmd_rd(cmd_rd),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.wait_ms(wait_ms),
		.red_led_on(red_led_on),
		.is_last(is_last)
	);

endmodule

// ----- test/ladder_command_checker.sv -----
// Checker for the keypad command block: predicts the command bytes of every accepted
// sample and compares them with the bytes popped from the result queue.
// Depends on lbpc_pkg for register indexes, key codes and command bytes.
module ladder_command_checker
	import lbpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [9:0]  sample,
	input  logic [31:0] now_ms,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_byte,
	input  logic [10:0] wait_ms,
	input  logic        red_led_on,
	input  logic        is_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [25:0] cfg_data,
	output int          fail_count,
	output int          exp_count
);

	typedef struct packed {
		logic [7:0]  cmd;
		logic [10:0] pause;
		logic        led;
		logic        last;
	} cmd_byte_t;

	// Shadow registers and press context
	logic [15:0] long_lim;
	logic [15:0] gap_lim;
	range_t      key_range [6];
	logic [9:0]  last_key;
	logic [31:0] start_ms;
	logic [31:0] hold_len;
	logic        long_seen;
	logic        menu_on;
	logic        reset_arm;

	cmd_byte_t   cmd_bytes_due [$];  // bytes still owed by the block, oldest first
	cmd_byte_t   seq [$];            // bytes of the sample being predicted
	int          bad = 0;

	// First range holding the value strictly inside it
	function automatic btn_t key_of(logic [9:0] v);
		for (int i = 0; i < 6; i++) begin
			if (v > key_range[i][9:0] && v < key_range[i][25:16]) begin
				return btn_t'(3'(i + 1));
			end
		end
		return BTN_NONE;
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic [10:0] w, input logic led);
		if (seq.size() < 6) begin
			seq.push_back('{b, w, led, 1'b0});
		end
	endtask

	task automatic add_full(input logic [7:0] code, input logic [10:0] second_wait,
			input logic led);
		add_byte(BYTE_PREFIX, '0, led);
		add_byte(BYTE_CMD, '0, led);
		add_byte(code, '0, led);
		add_byte(BYTE_PREFIX, second_wait, led);
		add_byte(BYTE_CMD, '0, led);
		add_byte(BYTE_RELEASE, '0, led);
	endtask

	task automatic add_step(input logic [7:0] code);
		add_byte(BYTE_PREFIX, '0, 1'b0);
		add_byte(BYTE_CMD, '0, 1'b0);
		add_byte(code, '0, 1'b0);
	endtask

	task automatic open_menu();
		menu_on = 1'b1;
		add_full(CODE_MENU, WAIT_BASE, 1'b1);
	endtask

	task automatic end_call();
		menu_on = 1'b0;
		add_full(CODE_END, WAIT_BASE, 1'b0);
	endtask

	task automatic short_action(input btn_t b);
		case (b)
			BTN_1: begin
				if (menu_on) open_menu();
				else add_full(CODE_CALL, WAIT_BASE, 1'b0);
			end
			BTN_2: begin
				if (menu_on) add_step(CODE_DOWN);
			end
			BTN_3: begin
				if (menu_on) add_step(CODE_UP);
				else end_call();
			end
			default: ;
		endcase
	endtask

	task automatic long_action(input btn_t b);
		case (b)
			BTN_1: begin
				if (reset_arm) begin
					reset_arm = 1'b0;
					add_full(CODE_RESET, WAIT_RESET, 1'b0);
				end else begin
					add_full(CODE_CALL, WAIT_REDIAL, 1'b0);
				end
			end
			BTN_2: open_menu();
			BTN_3: begin
				if (menu_on) end_call();
			end
			BTN_23: reset_arm = 1'b1;
			default: ;
		endcase
	endtask

	// Advance the press state by one sample and queue the bytes it causes
	task automatic predict_sample(input logic [9:0] cur, input logic [31:0] now);
		seq.delete();
		if (last_key != '0 && cur == '0) begin
			long_seen = 1'b0;
			if (hold_len < 32'(long_lim)) short_action(key_of(last_key));
		end
		if (cur != '0 && last_key == '0 && (now - start_ms) > 32'(gap_lim)) begin
			start_ms = now;
		end
		if (cur != '0) begin
			hold_len = now - start_ms;
		end else begin
			hold_len = '0;
			start_ms = '0;
		end
		if (hold_len > 32'(long_lim) && !long_seen) begin
			long_action(key_of(cur));
			long_seen = 1'b1;
		end
		last_key = cur;
		if (seq.size() > 0) seq[seq.size() - 1].last = 1'b1;
		foreach (seq[i]) cmd_bytes_due.push_back(seq[i]);
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			bad++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// Watch the three channels
	always @(posedge clk or negedge arst_n) begin : watch
		cmd_byte_t want;
		if (!arst_n) begin
			long_lim = LONG_PRESS_RST;
			gap_lim = TIMEOUT_RST;
			key_range[0] = BUTTON1_RST;
			key_range[1] = BUTTON2_RST;
			key_range[2] = BUTTON3_RST;
			key_range[3] = PAIR12_RST;
			key_range[4] = PAIR23_RST;
			key_range[5] = PAIR13_RST;
			last_key = '0;
			start_ms = '0;
			hold_len = '0;
			long_seen = 1'b0;
			menu_on = 1'b0;
			reset_arm = 1'b0;
			cmd_bytes_due.delete();
		end else begin
			// Compare a popped byte with the oldest one owed
			if (pop && !empty) begin
				if (cmd_bytes_due.size() == 0) begin
					bad++;
					$display("%0t: byte expected none actual %0d", $time, out_byte);
				end else begin
					want = cmd_bytes_due.pop_front();
					check_field("out_byte", want.cmd, out_byte);
					check_field("wait_ms", want.pause, wait_ms);
					check_field("red_led_on", want.led, red_led_on);
					check_field("is_last", want.last, is_last);
				end
			end
			// Mirror register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LONG_PRESS: long_lim = cfg_data[15:0];
					REG_TIMEOUT:    gap_lim = cfg_data[15:0];
					REG_BUTTON1:    key_range[0] = cfg_data;
					REG_BUTTON2:    key_range[1] = cfg_data;
					REG_BUTTON3:    key_range[2] = cfg_data;
					REG_PAIR12:     key_range[3] = cfg_data;
					REG_PAIR23:     key_range[4] = cfg_data;
					REG_PAIR13:     key_range[5] = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) predict_sample(sample, now_ms);
		end
		fail_count <= bad;
		exp_count <= cmd_bytes_due.size();
	end

endmodule

// ----- test/ladder_button_press_commander_core_test.sv -----
// Top of the keypad command block test: clock, reset, register settings and keypad
// press stimulus; the verdict comes from ladder_command_checker. Depends on lbpc_pkg.
module ladder_button_press_commander_core_test;
	import lbpc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [9:0]  sample = '0;
	logic [31:0] now_ms = '0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = REG_LONG_PRESS;
	logic [25:0] cfg_data = '0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic [10:0] wait_ms;
	logic        red_led_on;
	logic        is_last;
	logic        cfg_ready;
	int          fail_count;
	int          exp_count;

	// Stimulus-side copy of the settings, used to aim presses
	logic [31:0] clock_ms = 32'd50;
	logic [15:0] cur_long = LONG_PRESS_RST;
	logic [15:0] cur_gap = TIMEOUT_RST;
	range_t      cur_range [6];
	int          sent = 0;
	logic        calm = 1'b0;
	int          pop_hold = 0;

	ladder_button_press_commander_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.wait_ms(wait_ms),
		.red_led_on(red_led_on),
		.is_last(is_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ladder_command_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.wait_ms(wait_ms),
		.red_led_on(red_led_on),
		.is_last(is_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.exp_count(exp_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pop with random stall bursts, none once calm
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 3);
		end else begin
			pop <= 1'b1;
		end
	end

	// Push one sample request and hold it until taken
	task automatic send_sample(input logic [9:0] s, input logic [31:0] t);
		if (!calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		now_ms <= t;
		do @(posedge clk); while (full);
		sent++;
	endtask

	// Press a key, sample it while held, then release
	task automatic key_press(input logic [9:0] key, input logic [31:0] hold, input int mids);
		logic [31:0] t0;
		logic [31:0] t_rel;
		t0 = clock_ms;
		send_sample(key, t0);
		for (int i = 1; i <= mids; i++) send_sample(key, t0 + hold * i / mids);
		t_rel = t0 + hold + $urandom_range(1, 50);
		send_sample('0, t_rel);
		clock_ms = t_rel + $urandom_range(0, 600);
	endtask

	// Stop pushing until every owed byte has come, then let the pipeline settle
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (exp_count != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [25:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write every register from the stimulus copy; upper bits of the timers get noise
	task automatic load_regs();
		write_reg(REG_LONG_PRESS, {10'($urandom), cur_long});
		write_reg(REG_TIMEOUT, {10'($urandom), cur_gap});
		write_reg(REG_BUTTON1, cur_range[0]);
		write_reg(REG_BUTTON2, cur_range[1]);
		write_reg(REG_BUTTON3, cur_range[2]);
		write_reg(REG_PAIR12, cur_range[3]);
		write_reg(REG_PAIR23, cur_range[4]);
		write_reg(REG_PAIR13, cur_range[5]);
		cfg_valid <= 1'b0;
	endtask

	function automatic range_t rand_range();
		range_t r;
		int lo;
		int hi;
		r = range_t'($urandom);
		lo = $urandom_range(0, 1000);
		hi = lo + $urandom_range(2, 80);
		if (hi > 1023) hi = 1023;
		r[9:0] = 10'(lo);
		r[25:16] = 10'(hi);
		return r;
	endfunction

	task automatic random_config();
		cur_long = 16'($urandom_range(1, 3000));
		cur_gap = 16'($urandom_range(0, 400));
		foreach (cur_range[i]) cur_range[i] = rand_range();
	endtask

	// Value inside the chosen range when it has one, else any nonzero reading
	function automatic logic [9:0] pick_key(input int which);
		int lo;
		int hi;
		lo = cur_range[which][9:0];
		hi = cur_range[which][25:16];
		if (hi > lo + 1) return 10'($urandom_range(lo + 1, hi - 1));
		return 10'($urandom_range(1, 1023));
	endfunction

	// Mostly whole presses with random key and hold, the rest loose samples
	task automatic random_items(input int n);
		int first;
		int kind;
		logic [9:0] key;
		logic [31:0] hold;
		logic [31:0] t;
		bit paused;
		first = sent;
		paused = 1'b0;
		while (sent - first < n) begin
			if (!paused && sent - first >= n / 2) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 4) == 0) key = 10'($urandom_range(1, 1023));
				else key = pick_key($urandom_range(0, 5));
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					hold = (cur_long == 0) ? 32'd0 : 32'($urandom_range(0, cur_long - 1));
					key_press(key, hold, $urandom_range(0, 2));
				end else if (kind < 9) begin
					key_press(key, 32'(cur_long) + $urandom_range(1, 500), $urandom_range(1, 3));
				end else begin
					key_press(key, 32'(cur_long), $urandom_range(1, 2));
				end
			end else begin
				case ($urandom_range(0, 3))
					0: key = '0;
					1: key = 10'($urandom);
					2: key = '1;
					default: key = pick_key($urandom_range(0, 5));
				endcase
				case ($urandom_range(0, 4))
					0: t = $urandom;
					1: t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
					default: t = clock_ms + $urandom_range(0, 2 * cur_long + 10);
				endcase
				send_sample(key, t);
				clock_ms = t;
			end
		end
	endtask

	initial begin
		cur_range[0] = BUTTON1_RST;
		cur_range[1] = BUTTON2_RST;
		cur_range[2] = BUTTON3_RST;
		cur_range[3] = PAIR12_RST;
		cur_range[4] = PAIR23_RST;
		cur_range[5] = PAIR13_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed presses on the reset settings
		key_press(10'd175, 32'd40, 1);      // start too early to latch: short call
		clock_ms = 32'd10000;
		key_press(10'd925, 32'd100, 0);     // end call with the menu off
		key_press(10'd825, 32'd1500, 1);    // long 2 opens the menu with the red LED
		key_press(10'd825, 32'd100, 0);     // menu down
		key_press(10'd925, 32'd100, 0);     // menu up
		key_press(10'd175, 32'd100, 0);     // short 1 in the menu opens it again
		key_press(10'd925, 32'd1200, 1);    // long 3 in the menu ends the call
		key_press(10'd915, 32'd1200, 1);    // long pair 23 arms the reset
		key_press(10'd175, 32'd1200, 1);    // armed long 1 resets
		clock_ms = 32'hFFFF_FE00;
		key_press(10'd175, 32'd1200, 1);    // redial across the time wrap
		key_press(10'd175, 32'd1000, 1);    // hold equal to the limit: neither press
		send_sample('1, clock_ms);
		send_sample('0, clock_ms + 32'd20);
		drain();

		// Random settings
		random_config();
		load_regs();
		random_items(20);
		drain();

		// Low extremes: every nonzero hold is long, every start latches, wide button 1
		cur_long = '0;
		cur_gap = '0;
		foreach (cur_range[i]) cur_range[i] = rand_range();
		cur_range[0] = {10'd1023, 6'($urandom), 10'd0};
		load_regs();
		random_items(15);
		drain();

		// High extremes and ranges that hold nothing
		cur_long = '1;
		cur_gap = '1;
		foreach (cur_range[i]) cur_range[i] = rand_range();
		cur_range[1] = '1;
		cur_range[3] = '0;
		cur_range[5] = '1;
		load_regs();
		random_items(15);
		drain();

		// Last part with no idling on either side
		calm <= 1'b1;
		random_config();
		load_regs();
		random_items(20);
		drain();

		if (fail_count == 0) begin
			$display("ladder_button_press_commander_core_test OK");
		end else begin
			$display("ladder_button_press_commander_core_test NOT OK");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("ladder_button_press_commander_core_test NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lbpc_pkg.sv
rtl/lbpc_front.sv
rtl/lbpc_cmd_fifo.sv
rtl/lbpc_back.sv
rtl/ladder_button_press_commander_core.sv
test/ladder_command_checker.sv
test/ladder_button_press_commander_core_test.sv
